FILE: hw/rtl/ris_pkg.sv
// ris_pkg: shared types and codes for the record insertion sorter
// holds the command, result and record structs and the action and status codes
// no dependencies
package ris_pkg;

	localparam int KEY_W  = 20;
	localparam int WORD_W = 32;
	localparam int HELD_W = 9;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	// status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic              action;
		logic [KEY_W-1:0]  pressure_key;
		logic [WORD_W-1:0] altitude_word;
		logic [WORD_W-1:0] wind_dir_word;
		logic [WORD_W-1:0] wind_speed_word;
		logic [WORD_W-1:0] temperature_word;
		logic [WORD_W-1:0] dewpoint_word;
		logic [WORD_W-1:0] humidity_word;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [KEY_W-1:0]  out_pressure;
		logic [WORD_W-1:0] out_altitude;
		logic [WORD_W-1:0] out_wind_dir;
		logic [WORD_W-1:0] out_wind_speed;
		logic [WORD_W-1:0] out_temperature;
		logic [WORD_W-1:0] out_dewpoint;
		logic [WORD_W-1:0] out_humidity;
		logic [HELD_W-1:0] held_count;
	} res_t;

	// one stored record
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] altitude;
		logic [WORD_W-1:0] wind_dir;
		logic [WORD_W-1:0] wind_speed;
		logic [WORD_W-1:0] temperature;
		logic [WORD_W-1:0] dewpoint;
		logic [WORD_W-1:0] humidity;
	} record_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/ris_cell.sv
// ris_cell: one slot of the sorted record chain
// depends on ris_pkg
module ris_cell (
	input  logic              clk,
	input  ris_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  ris_pkg::record_t  new_rec,
	input  logic              prev_move,
	input  ris_pkg::record_t  prev_rec,
	input  ris_pkg::record_t  next_rec,
	output logic              move,
	output ris_pkg::record_t  rec
);

	ris_pkg::record_t rec_q;

	// empty slots and strictly smaller keys give way to the new record
	assign move = !occ || (rec_q.key < new_rec.key);
	assign rec  = rec_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (move) begin
				rec_q <= prev_move ? prev_rec : new_rec;
			end
		end else if (ctl.pop) begin
			rec_q <= next_rec;
		end
	end

endmodule

FILE: hw/rtl/record_insertion_sorter.sv
// record_insertion_sorter: top level of the descending stable record sorter
// depends on ris_pkg and ris_cell
//
// channel  dir  handshake              payload
// cmd      in   cmd_valid / cmd_ready  ris_pkg::cmd_t (action, key, six words)
// res      out  res_valid / res_ready  ris_pkg::res_t (status, record, count)
//
// one command per cycle while cmd_ready is high: every cell compares its key
// with the new key at once, so an insert or a pop finishes in the cycle of its transfer
// the result appears in the cycle after the command transfer, in a result register
// a new command is taken while the result register is empty or being drained
// reset clears the fill count and the result valid; record slots are not cleared
module record_insertion_sorter #(
	parameter int DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ris_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output ris_pkg::res_t res
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_nxt;
	logic               res_valid_q;
	ris_pkg::res_t      res_q;
	ris_pkg::res_t      res_nxt;

	logic               cmd_xfer;
	logic               full;
	logic               empty;
	logic               do_ins;
	logic               do_pop;
	ris_pkg::cell_ctl_t ctl;
	ris_pkg::record_t   new_rec;
	ris_pkg::record_t   rec_w  [DEPTH];
	logic               move_w [DEPTH];
	logic [CW+8:0]      held_wide;

	// result register frees up when empty or when its transfer happens now
	assign cmd_ready = !res_valid_q || res_ready;
	assign cmd_xfer  = cmd_valid && cmd_ready;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// a load into a full store and a pop from an empty one leave the chain alone
	assign do_ins = cmd_xfer && (cmd.action == ris_pkg::ACT_INSERT) && !full;
	assign do_pop = cmd_xfer && (cmd.action == ris_pkg::ACT_POP) && !empty;

	// ins, pop
	assign ctl = {do_ins, do_pop};

	// key first, then the six payload words in command order
	assign new_rec = {
		cmd.pressure_key,
		cmd.altitude_word,
		cmd.wind_dir_word,
		cmd.wind_speed_word,
		cmd.temperature_word,
		cmd.dewpoint_word,
		cmd.humidity_word
	};

	// the chain: slot 0 is the head (highest key, earliest among equals)
	// on insert each moving slot takes its upper neighbor, the topmost one takes
	// the new record; on pop every slot takes its lower neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             occ;
		logic             prev_move;
		ris_pkg::record_t prev_rec;
		ris_pkg::record_t next_rec;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_move = 1'b0;
			assign prev_rec  = new_rec;
		end else begin : g_body
			assign prev_move = move_w[i-1];
			assign prev_rec  = rec_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_rec = rec_w[i];
		end else begin : g_mid
			assign next_rec = rec_w[i+1];
		end

		ris_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ),
			.new_rec   (new_rec),
			.prev_move (prev_move),
			.prev_rec  (prev_rec),
			.next_rec  (next_rec),
			.move      (move_w[i]),
			.rec       (rec_w[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CW'(1);
		end else if (do_pop) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// held count is the fill count cut or padded to nine bits
	assign held_wide = {9'd0, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (cmd_xfer) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, zero record unless a record was popped
	always_comb begin
		res_nxt            = '0;
		res_nxt.held_count = held_wide[8:0];
		if (cmd.action == ris_pkg::ACT_INSERT) begin
			res_nxt.status = full ? ris_pkg::ST_FULL : ris_pkg::ST_INSERTED;
		end else if (empty) begin
			res_nxt.status = ris_pkg::ST_EMPTY;
		end else begin
			res_nxt.status          = ris_pkg::ST_POPPED;
			res_nxt.out_pressure    = rec_w[0].key;
			res_nxt.out_altitude    = rec_w[0].altitude;
			res_nxt.out_wind_dir    = rec_w[0].wind_dir;
			res_nxt.out_wind_speed  = rec_w[0].wind_speed;
			res_nxt.out_temperature = rec_w[0].temperature;
			res_nxt.out_dewpoint    = rec_w[0].dewpoint;
			res_nxt.out_humidity    = rec_w[0].humidity;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: hw/rtl/ris_checker.sv
// ris_checker: port-level checks for the record insertion sorter, and its bind
// depends on ris_pkg and record_insertion_sorter
module ris_checker #(
	parameter int DEPTH = 256
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input logic          res_valid,
	input logic          res_ready,
	input ris_pkg::res_t res
);

	localparam logic [8:0] FULL_HELD = 9'(DEPTH);

	// a held result stays put until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// every command transfer yields a result in the next cycle
	a_cmd_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> res_valid)
		else $error("command transfer without result");

	// no pressure, altitude or humidity field unless something was popped
	a_zero_rec: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ris_pkg::ST_POPPED) |->
		(res.out_pressure == '0) && (res.out_altitude == '0) &&
		(res.out_humidity == '0))
		else $error("record fields set without a pop");

	// empty status reports no records, full status reports a full store
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ris_pkg::ST_EMPTY) |-> res.held_count == '0)
		else $error("empty status with records held");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ris_pkg::ST_FULL) |-> res.held_count == FULL_HELD)
		else $error("full status with store not full");

endmodule

bind record_insertion_sorter ris_checker #(.DEPTH(DEPTH)) u_ris_checker (.*);
